// File: sv/cmphd_pkg.sv
// Shared types and constants for the compass heading pipeline.
// Holds the side-band struct, the cardinal code and the CORDIC step-angle table.
// No dependencies.
`default_nettype none

package cmphd_pkg;

    localparam int CORDIC_STEPS    = 60;
    localparam int ACC_WIDTH       = 64;
    localparam int NORM_TOP        = 60;   // normalised x lies in [2^60, 2^61)
    localparam int Z_SPLIT         = 30;   // angle split for the degree scaling
    localparam int DEAD_ZONE_WIDTH = 10;
    localparam logic [DEAD_ZONE_WIDTH-1:0] DEAD_ZONE_RESET = 10'd10;

    typedef enum logic [1:0] {
        CARD_NORTH,
        CARD_EAST,
        CARD_SOUTH,
        CARD_WEST
    } t_cardinal;

    // Travels alongside each item through the pipeline.
    typedef struct packed {
        logic      special;   // an axis sits in the dead zone
        t_cardinal card;      // forced heading when special
        logic      xneg;
        logic      yneg;
        logic      swap;      // |dx| > |dy|: octant angle is mirrored about 45 deg
    } t_side;

    typedef logic [ACC_WIDTH-1:0] t_angle_table [CORDIC_STEPS];

    // Restoring divide, elaboration only.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(1/m) in Q62 by its alternating series, m >= 2.
    function automatic logic [63:0] atan_recip_q62(input logic [63:0] m);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] k;
        logic [63:0] t;
        logic        neg;
        p   = udiv64(64'd1 << 62, m);
        sum = '0;
        k   = '0;
        neg = 1'b0;
        while (p != 64'd0) begin
            t   = udiv64(p, (k << 1) + 64'd1);
            sum = neg ? (sum - t) : (sum + t);
            neg = !neg;
            p   = udiv64(udiv64(p, m), m);
            k   = k + 64'd1;
        end
        return sum;
    endfunction

    // floor(n / d * 2^60), n < d < 2^62.
    function automatic logic [63:0] frac_q60(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] rem;
        logic [63:0] q;
        rem = n;
        q   = '0;
        for (int i = 0; i < 60; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= d) begin
                rem  = rem - d;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) as a Q60 fraction of 45 degrees.
    function automatic t_angle_table build_step_angles();
        t_angle_table tbl;
        logic [63:0]  quarter_pi;
        quarter_pi = atan_recip_q62(64'd2) + atan_recip_q62(64'd3);
        tbl[0] = 64'd1 << 60;
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            tbl[i] = frac_q60(atan_recip_q62(64'd1 << i), quarter_pi);
        end
        return tbl;
    endfunction

    localparam t_angle_table STEP_ANGLE = build_step_angles();

endpackage

`default_nettype wire

// File: sv/cmphd_cordic_stage.sv
// One vectoring-mode CORDIC micro-rotation with its pipeline register.
// Depends on cmphd_pkg (step-angle table, side-band struct).
`default_nettype none

module cmphd_cordic_stage #(
    parameter int STEP = 0
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_adv,
    input  wire logic                             i_valid,
    input  wire logic [cmphd_pkg::ACC_WIDTH-1:0] i_x,
    input  wire logic [cmphd_pkg::ACC_WIDTH-1:0] i_y,
    input  wire logic [cmphd_pkg::ACC_WIDTH-1:0] i_z,
    input  wire cmphd_pkg::t_side                i_side,
    output logic                                  o_valid,
    output logic      [cmphd_pkg::ACC_WIDTH-1:0] o_x,
    output logic      [cmphd_pkg::ACC_WIDTH-1:0] o_y,
    output logic      [cmphd_pkg::ACC_WIDTH-1:0] o_z,
    output cmphd_pkg::t_side                     o_side
);

    localparam int AW = cmphd_pkg::ACC_WIDTH;
    localparam logic [AW-1:0] ANGLE = cmphd_pkg::STEP_ANGLE[STEP];

    logic          r_valid;
    logic [AW-1:0] r_x, r_y, r_z;
    cmphd_pkg::t_side r_side;
    logic [AW-1:0] n_x, n_y, n_z;
    logic [AW-1:0] xs, ys;

    always_comb begin
        xs = i_x >> STEP;
        ys = AW'($signed(i_y) >>> STEP);
        if (!i_y[AW-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ANGLE;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// File: sv/compass_heading_from_offset.sv
// Compass heading (degrees clockwise from north) of a signed east/north offset.
// One item per cycle sustained while o_stall is low.
// The depth is set by the 60-step unrolled CORDIC, one micro-rotation per stage.
// Reset (synchronous, active low) empties the pipeline and sets dead_zone to 10.
// Depends on cmphd_pkg and cmphd_cordic_stage.
`default_nettype none

module compass_heading_from_offset #(
    parameter int COORD_WIDTH         = 32,
    parameter int COORD_FRACTION_BITS = 10,
    parameter int ANGLE_FRACTION_BITS = 8
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration: dead zone in coordinate LSBs
    input  wire logic                                  i_cfg_we,
    input  wire logic [cmphd_pkg::DEAD_ZONE_WIDTH-1:0] i_cfg_wdata,
    // offset transfer in
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic signed [COORD_WIDTH-1:0]         i_dx,
    input  wire logic signed [COORD_WIDTH-1:0]         i_dy,
    // heading transfer out
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic [9+ANGLE_FRACTION_BITS-1:0]           o_heading
);

    // ------------------------------------------------------------------
    // Sizes. The dead zone has integer LSB meaning, so the fraction count of
    // the coordinates never enters the arithmetic; it only documents scaling.
    // ------------------------------------------------------------------
    localparam int CW      = COORD_WIDTH;
    localparam int CFB     = COORD_FRACTION_BITS;
    localparam int AFB     = ANGLE_FRACTION_BITS;
    localparam int HW      = 9 + AFB;                 // 360 * 2^AFB < 2^HW
    localparam int AW      = cmphd_pkg::ACC_WIDTH;
    localparam int NSTEP   = cmphd_pkg::CORDIC_STEPS;
    localparam int DZW     = cmphd_pkg::DEAD_ZONE_WIDTH;
    localparam int ZS      = cmphd_pkg::Z_SPLIT;
    localparam int TH_W    = AW - ZS;
    localparam int SCALE_W = 6 + AFB;                 // 45 * 2^AFB
    localparam int PH_W    = TH_W + SCALE_W;
    localparam int PL_W    = ZS + SCALE_W;
    localparam int NORM_STAGES = 3;                   // two shift steps per stage

    localparam logic [SCALE_W-1:0] SCALE    = SCALE_W'(45) << AFB;
    localparam logic [HW-1:0]      UNIT_90  = HW'(90)  << AFB;
    localparam logic [HW-1:0]      UNIT_180 = HW'(180) << AFB;
    localparam logic [HW-1:0]      UNIT_270 = HW'(270) << AFB;
    localparam logic [HW-1:0]      UNIT_360 = HW'(360) << AFB;
    localparam logic [CW-1:0]      C_ONE    = CW'(1);
    localparam logic [AW-1:0]      ROUND_HALF = AW'(1) << (ZS - 1);
    localparam logic [CFB-1:0]     FRAC_ZERO  = '0;   // coordinate fraction field width

    // ------------------------------------------------------------------
    // Flow control: every stage moves together while the skid slot is empty.
    // The skid slot catches the item leaving the pipeline while the output
    // register is held, so o_stall comes straight from a flop.
    // ------------------------------------------------------------------
    logic adv;
    logic r_skid_valid;
    assign adv     = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // Dead zone register
    logic [DZW-1:0] r_dead_zone;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= cmphd_pkg::DEAD_ZONE_RESET;
        end else if (i_cfg_we) begin
            r_dead_zone <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: magnitudes. The most negative code negates to itself, which
    // read unsigned is exactly 2^(CW-1).
    // ------------------------------------------------------------------
    logic          r_a_valid;
    logic [CW-1:0] r_a_ax, r_a_ay;
    logic          r_a_xneg, r_a_yneg;
    logic [CW-1:0] dx_u, dy_u, n_a_ax, n_a_ay;

    always_comb begin
        dx_u   = $unsigned(i_dx);
        dy_u   = $unsigned(i_dy);
        n_a_ax = dx_u[CW-1] ? ((~dx_u) + C_ONE) : dx_u;
        n_a_ay = dy_u[CW-1] ? ((~dy_u) + C_ONE) : dy_u;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_valid && (FRAC_ZERO == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_ax   <= n_a_ax;
            r_a_ay   <= n_a_ay;
            r_a_xneg <= dx_u[CW-1];
            r_a_yneg <= dy_u[CW-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage B (norm slot 0): dead-zone tests, octant fold. The smaller
    // magnitude becomes y, the larger x, widened to the CORDIC word.
    // ------------------------------------------------------------------
    logic                 r_n_valid [NORM_STAGES+1];
    logic [AW-1:0]        r_n_x     [NORM_STAGES+1];
    logic [AW-1:0]        r_n_y     [NORM_STAGES+1];
    cmphd_pkg::t_side     r_n_side  [NORM_STAGES+1];

    logic [CW-1:0]        dz_ext;
    logic                 x_in_dz, y_in_dz, swap;
    cmphd_pkg::t_side     n_b_side;
    logic [AW-1:0]        n_b_x, n_b_y;

    always_comb begin
        dz_ext  = {{(CW-DZW){1'b0}}, r_dead_zone};
        x_in_dz = (r_a_ax <= dz_ext);
        y_in_dz = (r_a_ay <= dz_ext);
        swap    = (r_a_ax > r_a_ay);

        n_b_side.special = x_in_dz || y_in_dz;
        n_b_side.xneg    = r_a_xneg;
        n_b_side.yneg    = r_a_yneg;
        n_b_side.swap    = swap;
        priority if (x_in_dz) begin
            n_b_side.card = (!r_a_yneg && (r_a_ay != '0)) ? cmphd_pkg::CARD_NORTH
                                                           : cmphd_pkg::CARD_SOUTH;
        end else begin
            n_b_side.card = (!r_a_xneg && (r_a_ax != '0)) ? cmphd_pkg::CARD_EAST
                                                           : cmphd_pkg::CARD_WEST;
        end

        n_b_x = {{(AW-CW){1'b0}}, (swap ? r_a_ax : r_a_ay)};
        n_b_y = {{(AW-CW){1'b0}}, (swap ? r_a_ay : r_a_ax)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid[0] <= 1'b0;
        end else if (adv) begin
            r_n_valid[0] <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_n_x[0]    <= n_b_x;
            r_n_y[0]    <= n_b_y;
            r_n_side[0] <= n_b_side;
        end
    end

    // ------------------------------------------------------------------
    // Normalise: shift both until x lands in [2^60, 2^61). Binary search on
    // the shift count, 32/16, 8/4, 2/1 over three stages.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < NORM_STAGES; g++) begin : g_norm
        localparam int K1 = 32 >> (2 * g);
        localparam int K2 = 16 >> (2 * g);
        localparam logic [AW-1:0] LIM1 = AW'(1) << (cmphd_pkg::NORM_TOP + 1 - K1);
        localparam logic [AW-1:0] LIM2 = AW'(1) << (cmphd_pkg::NORM_TOP + 1 - K2);

        logic [AW-1:0] x1, y1, x2, y2;

        always_comb begin
            x1 = r_n_x[g];
            y1 = r_n_y[g];
            if (r_n_x[g] < LIM1) begin
                x1 = r_n_x[g] << K1;
                y1 = r_n_y[g] << K1;
            end
            x2 = x1;
            y2 = y1;
            if (x1 < LIM2) begin
                x2 = x1 << K2;
                y2 = y1 << K2;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_n_valid[g+1] <= 1'b0;
            end else if (adv) begin
                r_n_valid[g+1] <= r_n_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_n_x[g+1]    <= x2;
                r_n_y[g+1]    <= y2;
                r_n_side[g+1] <= r_n_side[g];
            end
        end
    end

    // ------------------------------------------------------------------
    // CORDIC, vectoring mode, one micro-rotation per stage. z accumulates
    // the angle as a Q60 fraction of 45 degrees.
    // ------------------------------------------------------------------
    logic             c_valid [NSTEP+1];
    logic [AW-1:0]    c_x     [NSTEP+1];
    logic [AW-1:0]    c_y     [NSTEP+1];
    logic [AW-1:0]    c_z     [NSTEP+1];
    cmphd_pkg::t_side c_side  [NSTEP+1];

    assign c_valid[0] = r_n_valid[NORM_STAGES];
    assign c_x[0]     = r_n_x[NORM_STAGES];
    assign c_y[0]     = r_n_y[NORM_STAGES];
    assign c_z[0]     = '0;
    assign c_side[0]  = r_n_side[NORM_STAGES];

    for (genvar s = 0; s < NSTEP; s++) begin : g_cordic
        cmphd_cordic_stage #(
            .STEP (s)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (c_valid[s]),
            .i_x     (c_x[s]),
            .i_y     (c_y[s]),
            .i_z     (c_z[s]),
            .i_side  (c_side[s]),
            .o_valid (c_valid[s+1]),
            .o_x     (c_x[s+1]),
            .o_y     (c_y[s+1]),
            .o_z     (c_z[s+1]),
            .o_side  (c_side[s+1])
        );
    end

    // ------------------------------------------------------------------
    // Stage M: scale to degrees. z is clamped at zero, split at bit 30 and
    // each half multiplied by 45 * 2^AFB.
    // ------------------------------------------------------------------
    logic             r_m_valid;
    logic [PH_W-1:0]  r_m_ph;
    logic [PL_W-1:0]  r_m_pl;
    cmphd_pkg::t_side r_m_side;
    logic [AW-1:0]    z_clamp;
    logic [TH_W-1:0]  z_hi;
    logic [ZS-1:0]    z_lo;
    logic [PH_W-1:0]  n_m_ph;
    logic [PL_W-1:0]  n_m_pl;

    always_comb begin
        z_clamp = c_z[NSTEP][AW-1] ? '0 : c_z[NSTEP];
        z_hi    = z_clamp[AW-1:ZS];
        z_lo    = z_clamp[ZS-1:0];
        n_m_ph  = {{SCALE_W{1'b0}}, z_hi} * {{TH_W{1'b0}}, SCALE};
        n_m_pl  = {{SCALE_W{1'b0}}, z_lo} * {{ZS{1'b0}}, SCALE};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (adv) begin
            r_m_valid <= c_valid[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m_ph   <= n_m_ph;
            r_m_pl   <= n_m_pl;
            r_m_side <= c_side[NSTEP];
        end
    end

    // ------------------------------------------------------------------
    // Stage R: recombine and round to nearest LSB -> octant angle phi.
    // ------------------------------------------------------------------
    logic             r_r_valid;
    logic [HW-1:0]    r_r_phi;
    cmphd_pkg::t_side r_r_side;
    logic [AW-1:0]    sum_deg;

    always_comb begin
        sum_deg = AW'(r_m_ph) + AW'(r_m_pl >> ZS) + ROUND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (adv) begin
            r_r_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_r_phi  <= sum_deg[ZS +: HW];
            r_r_side <= r_m_side;
        end
    end

    // ------------------------------------------------------------------
    // Stage Q: unfold octant and quadrant, wrap 360 to 0, or take the
    // cardinal heading when an axis sat in the dead zone.
    // ------------------------------------------------------------------
    logic          r_q_valid;
    logic [HW-1:0] r_q_heading;
    logic [HW-1:0] phi, quad, card_heading, n_q_heading;

    always_comb begin
        phi = r_r_side.swap ? (UNIT_90 - r_r_phi) : r_r_phi;

        priority if (!r_r_side.xneg && !r_r_side.yneg) begin
            quad = phi;
        end else if (!r_r_side.xneg) begin
            quad = UNIT_180 - phi;
        end else if (r_r_side.yneg) begin
            quad = UNIT_180 + phi;
        end else begin
            quad = UNIT_360 - phi;
        end
        if (quad >= UNIT_360) begin
            quad = quad - UNIT_360;
        end

        unique case (r_r_side.card)
            cmphd_pkg::CARD_NORTH: card_heading = '0;
            cmphd_pkg::CARD_EAST:  card_heading = UNIT_90;
            cmphd_pkg::CARD_SOUTH: card_heading = UNIT_180;
            cmphd_pkg::CARD_WEST:  card_heading = UNIT_270;
            default:               card_heading = '0;
        endcase

        n_q_heading = r_r_side.special ? card_heading : quad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (adv) begin
            r_q_valid <= r_r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q_heading <= n_q_heading;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid slot. Stage Q is drained whenever adv is
    // high; its item goes to the output register if that is free this
    // cycle, else into the skid slot, which then freezes the pipeline.
    // ------------------------------------------------------------------
    logic          r_out_valid;
    logic [HW-1:0] r_out_heading;
    logic [HW-1:0] r_skid_heading;
    logic          out_free, q_take;

    assign out_free = !r_out_valid || !i_stall;
    assign q_take   = adv && r_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid  <= r_skid_valid || q_take;
                r_skid_valid <= 1'b0;
            end else if (q_take) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_heading <= r_skid_valid ? r_skid_heading : r_q_heading;
        end
        if (q_take && !out_free) begin
            r_skid_heading <= r_q_heading;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_heading = r_out_heading;

endmodule

`default_nettype wire
